// ----- design/stable_priority_queue_top_defines.svh -----
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 4;
    localparam int REC_W       = 16;
    localparam int CONTACT_W   = 32;
    localparam int DUR_W       = 16;
    localparam int FILL_W      = 5;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_POP    = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [REC_W-1:0]     record;
        logic [CONTACT_W-1:0] contact;
        logic [DUR_W-1:0]     duration;
    } t_entry;

    // Control for every cell of the chain: en and op are broadcast, occupied is per cell.
    typedef struct packed {
        logic    en;
        t_action op;
        logic    occupied;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire spq_pkg::t_entry    i_new,
    input  wire spq_pkg::t_entry    i_prev,
    input  wire spq_pkg::t_entry    i_next,
    input  wire logic               i_prev_ge,
    output spq_pkg::t_entry         o_entry,
    output spq_pkg::t_entry         o_next,
    output logic                    o_ge
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Stored entry ranks ahead of the incoming one.
    assign o_ge = i_ctl.occupied && (r_entry.prio >= i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.en) begin
            case (i_ctl.op)
                ACT_INSERT: begin
                    if (o_ge) begin
                        n_entry = r_entry;
                    end else if (i_prev_ge) begin
                        n_entry = i_new;
                    end else begin
                        n_entry = i_prev;
                    end
                end
                ACT_POP: n_entry = i_next;
                default: n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

`default_nettype wire

// ----- design/stable_priority_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_top_defines.svh"

// Stable priority queue of spq_pkg::QUEUE_DEPTH entries held in a chain of cells,
// slot 0 at the head. Each beat is one insert or one pop: on an insert every
// cell compares its priority with the new entry in parallel and keeps, takes
// the new entry, or takes its neighbor's entry; on a pop every cell takes its
// successor's entry, all in the same edge. Equal priorities leave in arrival
// order. A new beat is taken in every cycle in which the result register is
// empty or its result is being taken; each beat yields one result with the
// status, the head after the operation (zero when empty) and the fill level.
// An insert into a full queue and a pop on an empty queue leave the queue
// unchanged and are flagged in the status. No clearing pass follows reset.
module stable_priority_queue_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [spq_pkg::PRIO_W-1:0]    i_priority_req,
    input  wire logic [spq_pkg::REC_W-1:0]     i_record_id,
    input  wire logic [spq_pkg::CONTACT_W-1:0] i_contact,
    input  wire logic [spq_pkg::DUR_W-1:0]     i_duration,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic                               o_head_valid,
    output logic [spq_pkg::PRIO_W-1:0]         o_head_priority,
    output logic [spq_pkg::REC_W-1:0]          o_head_record,
    output logic [spq_pkg::CONTACT_W-1:0]      o_head_contact,
    output logic [spq_pkg::DUR_W-1:0]          o_head_duration,
    output logic [spq_pkg::FILL_W-1:0]         o_fill_level
);
    import spq_pkg::*;

    t_count  r_count;
    t_count  n_count;
    logic    r_out_valid;
    logic    n_out_valid;
    t_status r_status;
    t_status n_status;
    logic    r_head_valid;
    t_entry  r_head;
    t_entry  n_head;

    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    logic    w_en;
    t_action w_op;
    t_entry  w_new;

    t_entry  w_entry [QUEUE_DEPTH];
    t_entry  w_next  [QUEUE_DEPTH];
    logic    w_ge    [QUEUE_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_op       = t_action'(i_action);
    assign w_full     = (r_count == t_count'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_new.prio     = i_priority_req;
    assign w_new.record   = i_record_id;
    assign w_new.contact  = i_contact;
    assign w_new.duration = i_duration;

    always_comb begin
        n_status = ST_DONE;
        w_en     = 1'b0;
        n_count  = r_count;
        case (w_op)
            ACT_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_en    = w_accept;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_en    = w_accept;
                    n_count = r_count - 1'b1;
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_cell_ctl w_ctl;
            t_entry    w_prev;
            t_entry    w_after;
            logic      w_prev_ge;

            assign w_ctl.en       = w_en;
            assign w_ctl.op       = w_op;
            assign w_ctl.occupied = (t_count'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_prev    = w_new;
                assign w_prev_ge = 1'b1;
            end else begin : g_body
                assign w_prev    = w_entry[gi-1];
                assign w_prev_ge = w_ge[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_after = w_entry[gi];
            end else begin : g_link
                assign w_after = w_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_new     (w_new),
                .i_prev    (w_prev),
                .i_next    (w_after),
                .i_prev_ge (w_prev_ge),
                .o_entry   (w_entry[gi]),
                .o_next    (w_next[gi]),
                .o_ge      (w_ge[gi])
            );
        end
    endgenerate

    // Report the head as it stands after this beat; zero it when empty.
    always_comb begin
        n_head      = (n_count == '0) ? '0 : w_next[0];
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_head_valid <= (n_count != '0);
            r_head       <= n_head;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_head_valid    = r_head_valid;
    assign o_head_priority = r_head.prio;
    assign o_head_record   = r_head.record;
    assign o_head_contact  = r_head.contact;
    assign o_head_duration = r_head.duration;
    assign o_fill_level    = FILL_W'(r_count);

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= t_count'(QUEUE_DEPTH), "fill count above queue depth")
    `SPQ_ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n, w_accept && w_op == ACT_POP && w_empty,
        o_status == ST_EMPTY && r_count == '0, "pop on empty queue not flagged")
    `SPQ_ASSERT_NEXT(a_insert_grow, i_clk, i_rst_n, w_accept && w_op == ACT_INSERT && !w_full,
        r_count == $past(r_count) + 1'b1 && o_head_valid, "insert did not add an entry")
    `SPQ_ASSERT_NOW(a_head_matches_fill, i_clk, i_rst_n, o_out_valid,
        o_head_valid == (r_count != '0), "head valid disagrees with fill count")

endmodule

`default_nettype wire

// ----- tb/stable_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps

module stable_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 270;
    localparam int HOLD_ITEMS   = 40;
    localparam int DRAIN_GUARD  = 5000;

    typedef struct packed {
        t_status             status;
        logic                head_valid;
        t_entry              head;
        logic [FILL_W-1:0]   fill;
    } t_result;

    typedef struct packed {
        t_action act;
        t_entry  ent;
        logic    typed;
        t_result want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 i_action = 1'b0;
    logic [PRIO_W-1:0]    i_priority_req = '0;
    logic [REC_W-1:0]     i_record_id = '0;
    logic [CONTACT_W-1:0] i_contact = '0;
    logic [DUR_W-1:0]     i_duration = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_status;
    logic                 o_head_valid;
    logic [PRIO_W-1:0]    o_head_priority;
    logic [REC_W-1:0]     o_head_record;
    logic [CONTACT_W-1:0] o_head_contact;
    logic [DUR_W-1:0]     o_head_duration;
    logic [FILL_W-1:0]    o_fill_level;

    // typed expectation travels with the beat it belongs to
    logic    req_typed = 1'b0;
    t_result req_want = '0;

    t_entry  sim_slot [QUEUE_DEPTH];
    int      sim_count = 0;
    t_result pending_results [$];
    t_row    directed_rows [$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_req = 1'b0;

    stable_priority_queue_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_priority_req  (i_priority_req),
        .i_record_id     (i_record_id),
        .i_contact       (i_contact),
        .i_duration      (i_duration),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_head_valid    (o_head_valid),
        .o_head_priority (o_head_priority),
        .o_head_record   (o_head_record),
        .o_head_contact  (o_head_contact),
        .o_head_duration (o_head_duration),
        .o_fill_level    (o_fill_level)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one insert or pop to the shadow queue and return the head afterward.
    function automatic t_result queue_step(input t_action act, input t_entry ent);
        t_result r;
        int      pos;
        int      i;
        r = '0;
        r.status = ST_DONE;
        if (act == ACT_INSERT) begin
            if (sim_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                // land behind every entry of equal or higher priority
                while (pos < sim_count && sim_slot[pos].prio >= ent.prio)
                    pos++;
                for (i = sim_count; i > pos; i--)
                    sim_slot[i] = sim_slot[i-1];
                sim_slot[pos] = ent;
                sim_count++;
            end
        end else begin
            if (sim_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                for (i = 1; i < sim_count; i++)
                    sim_slot[i-1] = sim_slot[i];
                sim_count--;
            end
        end
        if (sim_count > 0) begin
            r.head_valid = 1'b1;
            r.head = sim_slot[0];
        end
        r.fill = FILL_W'(sim_count);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            flag_mismatch(name, want, got);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result predicted;
        t_result want;
        t_entry  ent;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                ent = {i_priority_req, i_record_id, i_contact, i_duration};
                predicted = queue_step(t_action'(i_action), ent);
                pending_results.push_back(req_typed ? req_want : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with no request pending", 32'd0,
                                  32'(o_fill_level));
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("head_valid", 32'(want.head_valid), 32'(o_head_valid));
                    check_field("head_priority", 32'(want.head.prio), 32'(o_head_priority));
                    check_field("head_record", 32'(want.head.record), 32'(o_head_record));
                    check_field("head_contact", want.head.contact, o_head_contact);
                    check_field("head_duration", 32'(want.head.duration),
                                32'(o_head_duration));
                    check_field("fill_level", 32'(want.fill), 32'(o_fill_level));
                end
            end
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Hold the beat until it is taken; idle first as the phase asks.
    task automatic offer_request(input t_action act, input t_entry ent,
                                 input logic typed, input t_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_priority_req <= ent.prio;
        i_record_id    <= ent.record;
        i_contact      <= ent.contact;
        i_duration     <= ent.duration;
        req_typed      <= typed;
        req_want       <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Bursts of 20 requests pick at random between filling, draining and balanced traffic.
    task automatic run_random(input int count);
        int      n;
        int      ins_pct;
        int      prio_span;
        t_action act;
        t_entry  ent;
        ins_pct = 50;
        prio_span = 15;
        for (n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                case ($urandom_range(2))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    default: ins_pct = 85;
                endcase
                prio_span = $urandom_range(1) ? 15 : 2;
            end
            act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_POP;
            ent.prio     = PRIO_W'($urandom_range(prio_span));
            ent.record   = REC_W'($urandom);
            ent.contact  = $urandom;
            ent.duration = DUR_W'($urandom);
            offer_request(act, ent, 1'b0, '0);
        end
    endtask

    task automatic add_row(input t_action act, input t_entry ent, input logic typed,
                           input t_result want);
        t_row r;
        r.act = act;
        r.ent = ent;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    initial begin : stimulus
        int   k;
        int   phase;
        int   guard;
        t_row r;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(ACT_POP, '0, 1'b1, {ST_EMPTY, 1'b0, 68'h0, 5'd0});
        add_row(ACT_INSERT, '0, 1'b1, {ST_DONE, 1'b1, 68'h0, 5'd1});
        add_row(ACT_INSERT, {4'hF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
                {ST_DONE, 1'b1, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd2});
        // equal priority goes behind the earlier one
        add_row(ACT_INSERT, {4'hF, 16'h0001, 32'h0000_0001, 16'h0001}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h7, 16'h0002, 32'h8000_0000, 16'h8000}, 1'b0, '0);
        add_row(ACT_POP, {4'hF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0);
        add_row(ACT_INSERT, {4'hF, 16'h0010, 32'hA5A5_0010, 16'h5A10}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h0, 16'h0011, 32'h5A5A_0011, 16'hA511}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h7, 16'h0012, 32'hA5A5_0012, 16'h5A12}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h8, 16'h0013, 32'h5A5A_0013, 16'hA513}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h3, 16'h0014, 32'hA5A5_0014, 16'h5A14}, 1'b0, '0);
        add_row(ACT_INSERT, {4'hF, 16'h0015, 32'h5A5A_0015, 16'hA515}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h7, 16'h0016, 32'hA5A5_0016, 16'h5A16}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h1, 16'h0017, 32'h5A5A_0017, 16'hA517}, 1'b0, '0);
        add_row(ACT_INSERT, {4'hC, 16'h0018, 32'hA5A5_0018, 16'h5A18}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h7, 16'h0019, 32'h5A5A_0019, 16'hA519}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h0, 16'h001A, 32'hA5A5_001A, 16'h5A1A}, 1'b0, '0);
        add_row(ACT_INSERT, {4'h9, 16'h001B, 32'h5A5A_001B, 16'hA51B}, 1'b0, '0);
        add_row(ACT_INSERT, {4'hF, 16'h001C, 32'hA5A5_001C, 16'h5A1C}, 1'b0, '0);
        // queue is full now: reject, head unchanged
        add_row(ACT_INSERT, {4'hF, 16'hBEEF, 32'h1234_5678, 16'h4321}, 1'b0, '0);
        add_row(ACT_POP, '0, 1'b0, '0);
        add_row(ACT_POP, '0, 1'b0, '0);

        for (k = 0; k < directed_rows.size(); k++) begin
            r = directed_rows[k];
            offer_request(r.act, r.ent, r.typed, r.want);
        end

        // long receiver hold-off while the sender keeps pushing
        hold_req = 1'b1;
        run_random(HOLD_ITEMS);

        // pause the sender until everything is back
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            run_random(PHASE_ITEMS);
        end
        i_in_valid <= 1'b0;

        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending_results.size() != 0 && guard < DRAIN_GUARD);
        repeat (4) @(posedge i_clk);

        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            flag_mismatch("result never arrived", 32'd0, 32'd0);
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_top.sv
tb/stable_priority_queue_top_tb.sv
